[rtl/ect_pkg.sv]
// exposure countdown timer: shared types and constants
// no dependencies; imported by every module of the block but ect_chk
package ect_pkg;

  localparam int unsigned NowWidth  = 48;
  localparam int unsigned DurWidth  = 32;
  localparam int unsigned LeadWidth = 32;
  localparam int unsigned ProgWidth = 16;
  localparam int unsigned IvWidth   = 26;
  localparam int unsigned SecsWidth = 23;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 32;

  localparam logic [IvWidth-1:0]   MsPerS       = 26'd1000;
  localparam logic [LeadWidth-1:0] AmpLeadReset = 32'd500;
  localparam logic [IvWidth-1:0]   IvReset      = 26'd1000;

  // numerator at which the rounded seconds saturate: 2^23 * 1000
  localparam logic [63:0] SecsSatNum = 64'd8388608000;
  // floor(y / 125) = (y * RecipM) >> RecipShift for y < 2^30
  localparam int unsigned RecipShift = 37;
  localparam logic [30:0] RecipM     = 31'd1099511628;

  typedef enum logic [1:0] {
    OpTick   = 2'd0,
    OpStart  = 2'd1,
    OpAux    = 2'd2,
    OpAbort  = 2'd3
  } op_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgTimerRunning = 2'd0,
    CfgAmpLead      = 2'd1,
    CfgProgress     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                 timer_running;
    logic [LeadWidth-1:0] amp_lead;
    logic [IvWidth-1:0]   prog_iv;
  } cfg_t;

  typedef struct packed {
    logic                 timerx_expired;
    logic [SecsWidth-1:0] seconds_left;
    logic                 progress_report;
    logic                 exposure_aborted;
    logic                 exposure_done;
    logic                 amp_trigger;
    logic                 accepted;
  } res_t;

endpackage

[rtl/ect_cfg.sv]
// configuration registers of the exposure timer
// depends on ect_pkg; lead and interval are frozen while exposing
module ect_cfg import ect_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i,
  input  logic                    exposing_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgTimerRunning: cfg_d.timer_running = cfg_wdata_i[0];
        CfgAmpLead: begin
          if (!exposing_i) cfg_d.amp_lead = cfg_wdata_i[LeadWidth-1:0];
        end
        CfgProgress: begin
          // interval kept in milliseconds
          if (!exposing_i) cfg_d.prog_iv = IvWidth'(cfg_wdata_i[ProgWidth-1:0]) * MsPerS;
        end
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timer_running <= 1'b0;
      cfg_q.amp_lead      <= AmpLeadReset;
      cfg_q.prog_iv       <= IvReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/ect_secs.sv]
// rounded seconds left: (left + interval/2) / 1000, saturated to 23 bits
// depends on ect_pkg; divide by 8 as a shift, by 125 as a reciprocal multiply
module ect_secs import ect_pkg::*; #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic [TIME_BITS-1:0] left_i,
  input  logic [IvWidth-1:0]   prog_iv_i,
  output logic [SecsWidth-1:0] secs_o
);

  logic [TIME_BITS:0] num;
  logic               sat;
  logic [29:0]        y;
  logic [60:0]        prod;

  always_comb begin
    num  = (TIME_BITS+1)'(left_i) + (TIME_BITS+1)'(prog_iv_i[IvWidth-1:1]);
    sat  = (num >= (TIME_BITS+1)'(SecsSatNum));
    y    = num[32:3];
    prod = 61'(y) * 61'(RecipM);
    secs_o = sat ? '1 : prod[RecipShift+SecsWidth-1:RecipShift];
  end

endmodule

[rtl/ect_eval.sv]
// exposure and auxiliary timer state with the per-request evaluation
// depends on ect_pkg and ect_secs; state updates when a request leaves the input register
module ect_eval import ect_pkg::*; #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  op_e                  op_i,
  input  logic [TIME_BITS-1:0] now_i,
  input  logic [DurWidth-1:0]  dur_i,
  input  cfg_t                 cfg_i,
  output res_t                 res_o,
  output logic                 exposing_o
);

  logic                 exposing_q, exposing_d;
  logic                 amp_pending_q, amp_pending_d;
  logic                 aux_running_q, aux_running_d;
  logic [TIME_BITS-1:0] end_q, end_d;
  logic [TIME_BITS-1:0] amp_time_q, amp_time_d;
  logic [TIME_BITS-1:0] prog_time_q, prog_time_d;
  logic [TIME_BITS-1:0] aux_end_q, aux_end_d;
  logic [SecsWidth-1:0] secs;

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [DurWidth-1:0]  b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + (TIME_BITS+1)'(b);
    return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
  endfunction

  ect_secs #(.TIME_BITS(TIME_BITS)) u_secs (
    .left_i    (end_q - now_i),
    .prog_iv_i (cfg_i.prog_iv),
    .secs_o    (secs)
  );

  always_comb begin
    res_o         = '0;
    exposing_d    = exposing_q;
    amp_pending_d = amp_pending_q;
    aux_running_d = aux_running_q;
    end_d         = end_q;
    amp_time_d    = amp_time_q;
    prog_time_d   = prog_time_q;
    aux_end_d     = aux_end_q;

    unique case (op_i)
      OpTick: begin
        res_o.accepted = 1'b1;
        if (exposing_q) begin
          if (amp_pending_q && now_i >= amp_time_q) begin
            amp_pending_d     = 1'b0;
            res_o.amp_trigger = 1'b1;
          end
          if (now_i >= end_q) begin
            exposing_d          = 1'b0;
            res_o.exposure_done = 1'b1;
          end else if (cfg_i.prog_iv != '0 && now_i >= prog_time_q) begin
            prog_time_d           = sat_add(prog_time_q, DurWidth'(cfg_i.prog_iv));
            res_o.progress_report = 1'b1;
            res_o.seconds_left    = secs;
          end
        end
      end
      OpStart: begin
        if (cfg_i.timer_running && !exposing_q) begin
          end_d          = sat_add(now_i, dur_i);
          amp_time_d     = (end_d >= TIME_BITS'(cfg_i.amp_lead))
                           ? end_d - TIME_BITS'(cfg_i.amp_lead) : '0;
          amp_pending_d  = (cfg_i.amp_lead != '0);
          prog_time_d    = sat_add(now_i, DurWidth'(cfg_i.prog_iv));
          exposing_d     = 1'b1;
          res_o.accepted = 1'b1;
        end
      end
      OpAux: begin
        if (cfg_i.timer_running && !aux_running_q) begin
          aux_end_d      = sat_add(now_i, dur_i);
          aux_running_d  = 1'b1;
          res_o.accepted = 1'b1;
        end
      end
      OpAbort: begin
        if (exposing_q) begin
          amp_pending_d          = 1'b0;
          end_d                  = '0;
          exposing_d             = 1'b0;
          res_o.accepted         = 1'b1;
          res_o.exposure_done    = 1'b1;
          res_o.exposure_aborted = 1'b1;
        end
      end
      default: res_o = '0;
    endcase

    // auxiliary one-shot, checked on ticks and on aborts that took effect
    if ((op_i == OpTick || (op_i == OpAbort && exposing_q)) &&
        aux_running_q && now_i >= aux_end_q) begin
      aux_running_d        = 1'b0;
      res_o.timerx_expired = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exposing_q    <= 1'b0;
      amp_pending_q <= 1'b0;
      aux_running_q <= 1'b0;
      end_q         <= '0;
      amp_time_q    <= '0;
      prog_time_q   <= '0;
      aux_end_q     <= '0;
    end else if (fire_i) begin
      exposing_q    <= exposing_d;
      amp_pending_q <= amp_pending_d;
      aux_running_q <= aux_running_d;
      end_q         <= end_d;
      amp_time_q    <= amp_time_d;
      prog_time_q   <= prog_time_d;
      aux_end_q     <= aux_end_d;
    end
  end

  assign exposing_o = exposing_q;

endmodule

[rtl/exposure_countdown_timer.sv]
// exposure countdown timer top level: input register, evaluation, result register
// depends on ect_pkg, ect_cfg, ect_eval
//
//  channel  | direction | tdata (low bit up)                                   | tuser
//  s_axis   | in        | now_ms[47:0], duration_ms[79:48]                     | opcode[1:0]
//  m_axis   | out       | accepted, amp_trigger, exposure_done,                | -
//           |           | exposure_aborted, progress_report, seconds_left[27:5],|
//           |           | timerx_expired[28], zero fill to 32 bits             |
//  cfg      | in        | cfg_we_i, cfg_idx_i, cfg_wdata_i[31:0]               | -
//
// one request per cycle unless the output stalls; each result is registered before it is presented
// the timer state is read and written in the single evaluation stage
// reset clears the timer state and loads the register defaults
// a stalled result holds the output register; the input register keeps filling until both are full
module exposure_countdown_timer import ect_pkg::*; #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [79:0]             s_axis_tdata,  // now_ms, duration_ms
  input  logic [1:0]              s_axis_tuser,  // opcode
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [31:0]             m_axis_tdata,  // accepted, amp_trigger, exposure_done,
                                                 // exposure_aborted, progress_report,
                                                 // seconds_left, timerx_expired
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i
);

  logic                 in_valid_q;
  op_e                  op_q;
  logic [TIME_BITS-1:0] now_q;
  logic [DurWidth-1:0]  dur_q;
  logic                 out_valid_q;
  res_t                 res_q;
  res_t                 res;
  cfg_t                 cfg;
  logic                 exposing;
  logic                 advance;
  logic                 s_fire;
  logic [63:0]          now_ext;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign now_ext       = 64'(s_axis_tdata[NowWidth-1:0]);

  ect_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .exposing_i  (exposing),
    .cfg_o       (cfg)
  );

  ect_eval #(.TIME_BITS(TIME_BITS)) u_eval (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (in_valid_q && advance),
    .op_i       (op_q),
    .now_i      (now_q),
    .dur_i      (dur_q),
    .cfg_i      (cfg),
    .res_o      (res),
    .exposing_o (exposing)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_fire) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      op_q  <= op_e'(s_axis_tuser);
      now_q <= now_ext[TIME_BITS-1:0];
      dur_q <= s_axis_tdata[NowWidth+DurWidth-1:NowWidth];
    end
    if (advance && in_valid_q) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, res_q};

endmodule

[rtl/ect_chk.sv]
// port-level checks for the exposure countdown timer
// depends on nothing but the top-level ports; attached by the bind below
module ect_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // abort flag only with end of exposure
  a_abort_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2])
    else $error("abort flag without exposure end");

  // end of exposure and progress report exclude each other
  a_done_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[2] && m_axis_tdata[4]))
    else $error("exposure end together with progress report");

  // seconds left only with a report
  a_secs_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[4] |-> m_axis_tdata[27:5] == 23'd0)
    else $error("seconds left without progress report");

  // a refused request raises nothing
  a_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[31:1] == 31'd0)
    else $error("flags on a refused request");

endmodule

bind exposure_countdown_timer ect_chk u_ect_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
